// ===== hw/rtl/mvf_pkg.sv =====
// mvf_pkg: shared widths, codes and types of the volume fade engine
// no dependencies; compile first
`default_nettype none

package mvf_pkg;

    localparam int DEFAULT_CHANNELS = 4;
    localparam int MAX_RESULTS      = 8;
    localparam int RIDX_W           = $clog2(MAX_RESULTS);
    localparam int RCNT_W           = RIDX_W + 1;

    localparam int REQ_W   = 3;
    localparam int CH_OUT_W = 2;
    localparam int ACT_W   = 2;
    localparam int VOL_W   = 7;
    localparam int FT_W    = 8;
    localparam int TICK_W  = 10;
    localparam int LEN_W   = 15;
    localparam int PROD_W  = VOL_W + LEN_W;
    localparam int Q_W     = VOL_W;

    localparam logic [VOL_W-1:0] FULL_VOLUME    = 7'd100;
    localparam logic [VOL_W-1:0] TICKS_PER_UNIT = 7'd100;
    localparam logic [LEN_W-1:0] ELAPSED_MAX    = '1;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PLAY     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_STOP     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SETVOL   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TICK     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_STOP_ALL = 3'd4;

    // action codes
    localparam logic [ACT_W-1:0] ACT_SETVOL = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PLAY   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_STOP   = 2'd2;

    typedef struct packed {
        logic [CH_OUT_W-1:0] ch;
        logic [ACT_W-1:0]    action;
        logic [VOL_W-1:0]    vol;
        logic                flag;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } push_t;

    typedef struct packed {
        logic             go;
        logic [VOL_W-1:0] start_vol;
        logic [VOL_W-1:0] target_vol;
        logic [LEN_W-1:0] elapsed;
        logic [LEN_W-1:0] length;
    } interp_req_t;

    typedef struct packed {
        logic             done;
        logic [VOL_W-1:0] vol;
    } interp_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mvf_intf.sv =====
// mvf_cmd_if and mvf_act_if: valid/ready channels for requests and actions
// depends on mvf_pkg for field widths
`default_nettype none

interface mvf_cmd_if;
    import mvf_pkg::*;

    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [1:0]        channel;
    logic [VOL_W-1:0]  volume;
    logic [FT_W-1:0]   fade_time;
    logic [TICK_W-1:0] tick_count;
    logic              mode_flag;

    modport source (
        output valid, req_type, channel, volume, fade_time, tick_count, mode_flag,
        input  ready
    );
    modport sink (
        input  valid, req_type, channel, volume, fade_time, tick_count, mode_flag,
        output ready
    );
endinterface

interface mvf_act_if;
    import mvf_pkg::*;

    logic                valid;
    logic                ready;
    logic [CH_OUT_W-1:0] out_channel;
    logic [ACT_W-1:0]    action;
    logic [VOL_W-1:0]    out_volume;
    logic                out_flag;
    logic                last;

    modport source (
        output valid, out_channel, action, out_volume, out_flag, last,
        input  ready
    );
    modport sink (
        input  valid, out_channel, action, out_volume, out_flag, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/multichannel_volume_fade_core.sv =====
// multichannel_volume_fade_core: per-channel linear volume fade engine
// depends on mvf_pkg, mvf_intf, mvf_interp, mvf_rbuf
//
//  channel | dir | payload                                              | transaction
//  cmd     | in  | req_type channel volume fade_time tick_count mode_flag | one request
//  act     | out | out_channel action out_volume out_flag last            | one action
//
// a request is taken only when the sequencer is idle and the previous actions are drained
// play, stop and set volume each run through their own states; a fading stop of a running fade also interpolates
// tick: scans every channel, and each active channel runs through the shared interpolation unit
//   (one multiply, 7 divide steps and a result state), with one more state on a self stop
// actions then leave one per cycle from the result buffer; act.ready stalls only the drain
// rst_n clears all fade state, the sequencer and the result buffer at once
`default_nettype none

module multichannel_volume_fade_core #(
    parameter int CHANNELS = mvf_pkg::DEFAULT_CHANNELS
) (
    input  wire        clk,
    input  wire        rst_n,
    mvf_cmd_if.sink    cmd,
    mvf_act_if.source  act
);
    import mvf_pkg::*;

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(CHANNELS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PLAY,
        S_PLAY2,
        S_STOP,
        S_STOP_W,
        S_SETV,
        S_SCAN,
        S_TICK_W,
        S_TICK_STOP,
        S_STOPALL,
        S_FLUSH
    } state_t;

    state_t state_reg, state_next;

    // per-channel fade state
    logic [LEN_W-1:0] len_reg   [CHANNELS];
    logic [LEN_W-1:0] len_next  [CHANNELS];
    logic [LEN_W-1:0] el_reg    [CHANNELS];
    logic [LEN_W-1:0] el_next   [CHANNELS];
    logic [VOL_W-1:0] svol_reg  [CHANNELS];
    logic [VOL_W-1:0] svol_next [CHANNELS];
    logic [VOL_W-1:0] tvol_reg  [CHANNELS];
    logic [VOL_W-1:0] tvol_next [CHANNELS];

    // latched request
    logic [VOL_W-1:0]  vol_reg;
    logic [FT_W-1:0]   ft_reg;
    logic [LEN_W-1:0]  flen_reg;
    logic [TICK_W-1:0] ticks_reg;
    logic              flag_reg;
    logic [CNT_W-1:0]  idx_reg, idx_next;

    logic [CH_W-1:0]   cur;
    logic [LEN_W-1:0]  cur_len;
    logic [LEN_W-1:0]  cur_el;
    logic [VOL_W-1:0]  cur_svol;
    logic [VOL_W-1:0]  cur_tvol;
    logic [LEN_W:0]    el_sum;
    logic [LEN_W-1:0]  el_sat;
    logic              idx_end;
    logic              ch_bad;
    logic [VOL_W-1:0]  vol_in;

    push_t             push;
    logic              flush;
    logic              drain_busy;
    interp_req_t       ip_req;
    interp_rsp_t       ip_rsp;

    assign cur      = idx_reg[CH_W-1:0];
    assign cur_len  = len_reg[cur];
    assign cur_el   = el_reg[cur];
    assign cur_svol = svol_reg[cur];
    assign cur_tvol = tvol_reg[cur];
    assign idx_end  = (idx_reg == CNT_W'(CHANNELS));

    // elapsed count saturates at its width
    assign el_sum = {1'b0, cur_el} + (LEN_W+1)'(ticks_reg);
    assign el_sat = el_sum[LEN_W] ? ELAPSED_MAX : el_sum[LEN_W-1:0];

    assign ch_bad = (int'(cmd.channel) >= CHANNELS);
    assign vol_in = (cmd.volume > FULL_VOLUME) ? FULL_VOLUME : cmd.volume;

    assign cmd.ready = (state_reg == S_IDLE) && !drain_busy;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        el_next    = el_reg;
        svol_next  = svol_reg;
        tvol_next  = tvol_reg;
        flush      = 1'b0;

        push.valid      = 1'b0;
        push.res.ch     = CH_OUT_W'(idx_reg);
        push.res.action = ACT_SETVOL;
        push.res.vol    = '0;
        push.res.flag   = 1'b0;

        ip_req.go         = 1'b0;
        ip_req.start_vol  = cur_svol;
        ip_req.target_vol = cur_tvol;
        ip_req.elapsed    = cur_el;
        ip_req.length     = cur_len;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid && cmd.ready)
                begin
                    idx_next = CNT_W'(cmd.channel);
                    priority if ((cmd.req_type <= REQ_SETVOL) && ch_bad)
                    begin
                        state_next = S_FLUSH;
                    end
                    else if (cmd.req_type == REQ_PLAY)
                    begin
                        state_next = S_PLAY;
                    end
                    else if (cmd.req_type == REQ_STOP)
                    begin
                        state_next = S_STOP;
                    end
                    else if (cmd.req_type == REQ_SETVOL)
                    begin
                        state_next = S_SETV;
                    end
                    else if (cmd.req_type == REQ_TICK)
                    begin
                        idx_next   = '0;
                        state_next = S_SCAN;
                    end
                    else if (cmd.req_type == REQ_STOP_ALL)
                    begin
                        idx_next   = '0;
                        state_next = S_STOPALL;
                    end
                    else
                    begin
                        // unused request codes cause nothing
                        state_next = S_FLUSH;
                    end
                end
            end
            S_PLAY:
            begin
                len_next[cur] = flen_reg;
                if (ft_reg != '0)
                begin
                    svol_next[cur] = '0;
                    el_next[cur]   = '0;
                    push.valid     = 1'b1;
                end
                state_next = S_PLAY2;
            end
            S_PLAY2:
            begin
                push.valid      = 1'b1;
                push.res.action = ACT_PLAY;
                push.res.flag   = flag_reg;
                state_next      = S_FLUSH;
            end
            S_STOP:
            begin
                svol_next[cur] = cur_tvol;
                tvol_next[cur] = '0;
                el_next[cur]   = '0;
                len_next[cur]  = flen_reg;
                if (ft_reg == '0)
                begin
                    push.valid      = 1'b1;
                    push.res.action = ACT_STOP;
                    push.res.flag   = flag_reg;
                    state_next      = S_FLUSH;
                end
                else if ((cur_len != '0) && (cur_el < cur_len))
                begin
                    // fade out from where the running fade stands now
                    ip_req.go  = 1'b1;
                    state_next = S_STOP_W;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_STOP_W:
            begin
                if (ip_rsp.done)
                begin
                    svol_next[cur] = ip_rsp.vol;
                    state_next     = S_FLUSH;
                end
            end
            S_SETV:
            begin
                el_next[cur]  = '0;
                len_next[cur] = flen_reg;
                if (ft_reg == '0)
                begin
                    push.valid   = 1'b1;
                    push.res.vol = vol_reg;
                end
                else
                begin
                    svol_next[cur] = cur_tvol;
                end
                tvol_next[cur] = vol_reg;
                state_next     = S_FLUSH;
            end
            S_SCAN:
            begin
                priority if (idx_end)
                begin
                    state_next = S_FLUSH;
                end
                else if (cur_len == '0)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    el_next[cur] = el_sat;
                    ip_req.go    = 1'b1;
                    if (el_sat >= cur_len)
                    begin
                        // fade reaches its end on this tick
                        len_next[cur]  = '0;
                        ip_req.elapsed = cur_len;
                    end
                    else
                    begin
                        ip_req.elapsed = el_sat;
                    end
                    state_next = S_TICK_W;
                end
            end
            S_TICK_W:
            begin
                if (ip_rsp.done)
                begin
                    push.valid   = 1'b1;
                    push.res.vol = ip_rsp.vol;
                    if ((ip_rsp.vol == '0) && (cur_tvol == '0))
                    begin
                        state_next = S_TICK_STOP;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_TICK_STOP:
            begin
                // faded out to silence: stop the voice
                push.valid      = 1'b1;
                push.res.action = ACT_STOP;
                len_next[cur]   = '0;
                idx_next        = idx_reg + 1'b1;
                state_next      = S_SCAN;
            end
            S_STOPALL:
            begin
                if (idx_end)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    push.valid      = 1'b1;
                    push.res.action = ACT_STOP;
                    len_next[cur]   = '0;
                    idx_next        = idx_reg + 1'b1;
                end
            end
            S_FLUSH:
            begin
                flush      = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // request fields are payload and need no reset
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            vol_reg   <= vol_in;
            ft_reg    <= cmd.fade_time;
            flen_reg  <= LEN_W'(cmd.fade_time) * LEN_W'(TICKS_PER_UNIT);
            ticks_reg <= cmd.tick_count;
            flag_reg  <= cmd.mode_flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                len_reg[i]  <= '0;
                el_reg[i]   <= '0;
                svol_reg[i] <= '0;
                tvol_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            el_reg    <= el_next;
            svol_reg  <= svol_next;
            tvol_reg  <= tvol_next;
        end
    end

    mvf_interp u_interp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ip_req),
        .rsp   (ip_rsp)
    );

    mvf_rbuf u_rbuf (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .flush (flush),
        .busy  (drain_busy),
        .act   (act)
    );

    // interpolation results only arrive while the sequencer waits for them
    assert property (@(posedge clk) disable iff (!rst_n)
        ip_rsp.done |-> ((state_reg == S_STOP_W) || (state_reg == S_TICK_W)))
        else $error("interpolation result outside a wait state");

    // an interpolated volume stays within range
    assert property (@(posedge clk) disable iff (!rst_n)
        ip_rsp.done |-> (ip_rsp.vol <= FULL_VOLUME))
        else $error("interpolated volume above full scale");

    // the drain starts only after the sequencer finished a request
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(drain_busy) |-> $past(state_reg == S_FLUSH))
        else $error("result drain started mid request");

    // a new request leaves the idle state at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> (state_reg != S_IDLE))
        else $error("accepted request not started");

endmodule

`default_nettype wire

// ===== hw/rtl/mvf_interp.sv =====
// mvf_interp: shared interpolation unit, one multiply then restoring division
// depends on mvf_pkg
`default_nettype none

module mvf_interp (
    input  wire                  clk,
    input  wire                  rst_n,
    input  mvf_pkg::interp_req_t req,
    output mvf_pkg::interp_rsp_t rsp
);
    import mvf_pkg::*;

    localparam int STEP_W = $clog2(Q_W);

    typedef enum logic [1:0] {
        IP_IDLE,
        IP_MUL,
        IP_DIV,
        IP_OUT
    } ip_state_t;

    ip_state_t          state_reg;
    logic [VOL_W-1:0]   start_reg;
    logic               neg_reg;
    logic [VOL_W-1:0]   mag_reg;
    logic [LEN_W-1:0]   el_reg;
    logic [PROD_W-1:0]  rem_reg;
    logic [PROD_W-1:0]  dsh_reg;
    logic [Q_W-1:0]     q_reg;
    logic [STEP_W-1:0]  step_reg;

    logic               fits;
    logic signed [VOL_W+1:0] sum;

    assign fits = (rem_reg >= dsh_reg);

    // quotient never exceeds the volume difference, so the clamp is a guard
    always_comb
    begin
        if (neg_reg)
        begin
            sum = $signed({2'b00, start_reg}) - $signed({2'b00, q_reg});
        end
        else
        begin
            sum = $signed({2'b00, start_reg}) + $signed({2'b00, q_reg});
        end
    end

    always_comb
    begin
        rsp.done = (state_reg == IP_OUT);
        if (sum[VOL_W+1])
        begin
            rsp.vol = '0;
        end
        else if (sum > $signed({2'b00, FULL_VOLUME}))
        begin
            rsp.vol = FULL_VOLUME;
        end
        else
        begin
            rsp.vol = sum[VOL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IP_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                IP_IDLE:
                begin
                    if (req.go)
                    begin
                        start_reg <= req.start_vol;
                        neg_reg   <= (req.target_vol < req.start_vol);
                        mag_reg   <= (req.target_vol < req.start_vol)
                                     ? (req.start_vol - req.target_vol)
                                     : (req.target_vol - req.start_vol);
                        el_reg    <= req.elapsed;
                        dsh_reg   <= PROD_W'({req.length, (Q_W-1)'(0)});
                        state_reg <= IP_MUL;
                    end
                end
                IP_MUL:
                begin
                    rem_reg   <= PROD_W'(mag_reg) * PROD_W'(el_reg);
                    q_reg     <= '0;
                    step_reg  <= '0;
                    state_reg <= IP_DIV;
                end
                IP_DIV:
                begin
                    if (fits)
                    begin
                        rem_reg <= rem_reg - dsh_reg;
                    end
                    q_reg    <= {q_reg[Q_W-2:0], fits};
                    dsh_reg  <= dsh_reg >> 1;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(Q_W-1))
                    begin
                        state_reg <= IP_OUT;
                    end
                end
                IP_OUT:
                begin
                    state_reg <= IP_IDLE;
                end
                default:
                begin
                    state_reg <= IP_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mvf_rbuf.sv =====
// mvf_rbuf: collects the actions of one request, then drains them with last
// depends on mvf_pkg and mvf_act_if
`default_nettype none

module mvf_rbuf (
    input  wire             clk,
    input  wire             rst_n,
    input  mvf_pkg::push_t  push,
    input  wire             flush,
    output logic            busy,
    mvf_act_if.source       act
);
    import mvf_pkg::*;

    result_t             buf_mem [MAX_RESULTS];
    logic [RCNT_W-1:0]   cnt_reg;
    logic [RIDX_W-1:0]   rd_reg;
    logic                drain_reg;
    logic                ovalid_reg;
    result_t             ores_reg;
    logic                olast_reg;
    logic                is_last;

    assign busy      = drain_reg;
    assign is_last   = ({1'b0, rd_reg} == (cnt_reg - 1'b1));

    assign act.valid       = ovalid_reg;
    assign act.out_channel = ores_reg.ch;
    assign act.action      = ores_reg.action;
    assign act.out_volume  = ores_reg.vol;
    assign act.out_flag    = ores_reg.flag;
    assign act.last        = olast_reg;

    // anything past the result limit is dropped
    always_ff @(posedge clk)
    begin
        if (push.valid && (cnt_reg != RCNT_W'(MAX_RESULTS)))
        begin
            buf_mem[cnt_reg[RIDX_W-1:0]] <= push.res;
        end
        if (drain_reg && (!ovalid_reg || act.ready))
        begin
            ores_reg  <= buf_mem[rd_reg];
            olast_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            rd_reg     <= '0;
            drain_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (push.valid && (cnt_reg != RCNT_W'(MAX_RESULTS)))
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (flush && (cnt_reg != '0))
            begin
                drain_reg <= 1'b1;
                rd_reg    <= '0;
            end
            if (drain_reg && (!ovalid_reg || act.ready))
            begin
                ovalid_reg <= 1'b1;
                rd_reg     <= rd_reg + 1'b1;
                if (is_last)
                begin
                    drain_reg <= 1'b0;
                    cnt_reg   <= '0;
                end
            end
            else if (ovalid_reg && act.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
